[hdl/npcm_pkg.sv]
package npcm_pkg;

    // Default number of palette cells in the chain
    localparam int PALETTE_DEPTH_DEF = 16;

    // Field widths
    localparam int OP_W    = 1;
    localparam int ENTRY_W = 4;
    localparam int COLOR_W = 32;
    localparam int DIST_W  = 10;
    localparam int SIZE_W  = 5;
    localparam int CHAN_W  = 8;

    // Kind of input word, carried in tuser
    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_MATCH = 1'b1;

    // Reset value of the searched palette size
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // One slot of the chain: the word in flight and the best match so far
    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    op;
        logic [ENTRY_W-1:0] entry_index;
        logic [COLOR_W-1:0] pixel;
        logic [DIST_W-1:0]  best_dist;
        logic [COLOR_W-1:0] best_color;
    } t_slot;

endpackage

[hdl/npcm_cell.sv]
module npcm_cell
    import npcm_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [SIZE_W-1:0] i_size,
    input  t_slot             i_slot,
    input  logic [IDX_W-1:0]  i_best_idx,
    output t_slot             o_slot,
    output logic [IDX_W-1:0]  o_best_idx
);

    localparam bit                 SIZE_REACH = (CELL_IDX < (1 << SIZE_W));
    localparam bit                 LOAD_REACH = (CELL_IDX < (1 << ENTRY_W));
    localparam logic [SIZE_W-1:0]  CELL_SIZE  = SIZE_W'(CELL_IDX);
    localparam logic [ENTRY_W-1:0] CELL_ENTRY = ENTRY_W'(CELL_IDX);
    localparam logic [IDX_W-1:0]   CELL_ID    = IDX_W'(CELL_IDX);

    logic [COLOR_W-1:0] r_entry;
    t_slot              r_slot;
    logic [IDX_W-1:0]   r_best_idx;
    t_slot              n_slot;
    logic [IDX_W-1:0]   n_best_idx;

    logic [CHAN_W-1:0]  diff_b, diff_g, diff_r;
    logic [DIST_W-1:0]  cand_dist;
    logic               in_range;
    logic               take;
    logic               load_hit;

    // Absolute channel differences and their sum
    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        diff_b    = abs_diff(i_slot.pixel[7:0],   r_entry[7:0]);
        diff_g    = abs_diff(i_slot.pixel[15:8],  r_entry[15:8]);
        diff_r    = abs_diff(i_slot.pixel[23:16], r_entry[23:16]);
        cand_dist = DIST_W'(diff_b) + DIST_W'(diff_g) + DIST_W'(diff_r);
    end

    // Cell zero always seeds the search; later cells join only below the size
    always_comb begin
        in_range = (CELL_IDX == 0) || (SIZE_REACH && (i_size > CELL_SIZE));
        take     = (CELL_IDX == 0) || (in_range && (cand_dist < i_slot.best_dist));
        load_hit = i_slot.valid && (i_slot.op == OP_LOAD) && LOAD_REACH
                   && (i_slot.entry_index == CELL_ENTRY);
    end

    // Update the best match as the word passes
    always_comb begin
        n_slot     = i_slot;
        n_best_idx = i_best_idx;
        if (i_slot.op == OP_MATCH && take) begin
            n_slot.best_dist  = cand_dist;
            n_slot.best_color = r_entry;
            n_best_idx        = CELL_ID;
        end
    end

    // Store the entry when its load word reaches this cell
    always_ff @(posedge i_clk) begin
        if (i_adv && load_hit) begin
            r_entry <= i_slot.pixel;
        end
    end

    // Advance the slot register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else if (i_adv) begin
            r_slot.valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_slot.op          <= n_slot.op;
            r_slot.entry_index <= n_slot.entry_index;
            r_slot.pixel       <= n_slot.pixel;
            r_slot.best_dist   <= n_slot.best_dist;
            r_slot.best_color  <= n_slot.best_color;
            r_best_idx         <= n_best_idx;
        end
    end

    assign o_slot     = r_slot;
    assign o_best_idx = r_best_idx;

endmodule

[hdl/nearest_palette_color_match.sv]
// Channel  | Dir | tdata (low bit up)                                  | tuser
// ---------+-----+-----------------------------------------------------+---------
// s_axis   | in  | entry_index[3:0], pixel[35:4], zero pad[39:36]      | op
// m_axis   | out | matched_color[31:0], matched_index[35:32],          | -
//          |     | match_distance[45:36], zero pad[47:46]              |
// cfg      | in  | i_cfg_wr_en, i_cfg_wr_data = palette_size[4:0]      | -
//
// One word is taken per cycle while the chain is not held; a word passes
// through the registered chain cell by cell, each cell holding one palette entry.
// Load words travel the chain too and write their entry on the way, so order
// against match words is kept; they give no output word.
// Reset clears the slot valid bits and sets palette_size to 16.
// The whole chain holds while an output word waits with m_axis_tready low.
module nearest_palette_color_match
    import npcm_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,  // palette_size
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,   // entry_index, pixel, zero pad
    input  logic [OP_W-1:0]   s_axis_tuser,   // op
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata    // matched_color, matched_index,
                                              // match_distance, zero pad
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [SIZE_W-1:0] r_size;
    t_slot             slot     [0:PALETTE_DEPTH];
    logic [IDX_W-1:0]  best_idx [0:PALETTE_DEPTH];
    logic              adv;
    logic [IDX_W+3:0]  idx_ext;

    // Hold palette_size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    // Stall the chain only while an output word is refused
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Build the slot entering the chain
    always_comb begin
        slot[0].valid       = s_axis_tvalid;
        slot[0].op          = s_axis_tuser;
        slot[0].entry_index = s_axis_tdata[3:0];
        slot[0].pixel       = s_axis_tdata[35:4];
        slot[0].best_dist   = '0;
        slot[0].best_color  = '0;
        best_idx[0]         = '0;
    end

    // Chain of palette cells
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        npcm_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_size     (r_size),
            .i_slot     (slot[g]),
            .i_best_idx (best_idx[g]),
            .o_slot     (slot[g+1]),
            .o_best_idx (best_idx[g+1])
        );
    end

    // Present match results from the last cell; drop load words there
    assign idx_ext       = {4'b0, best_idx[PALETTE_DEPTH]};
    assign m_axis_tvalid = slot[PALETTE_DEPTH].valid
                           && (slot[PALETTE_DEPTH].op == OP_MATCH);
    assign m_axis_tdata  = {2'b0,
                            slot[PALETTE_DEPTH].best_dist,
                            idx_ext[3:0],
                            slot[PALETTE_DEPTH].best_color};

endmodule
